>>> hdl/cpl_pkg.sv
// Shared types and constants for the closest-point-on-line block.
// Used by every module under hdl; no dependencies of its own.
package cpl_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF  = 16;

	// Configuration registers.
	localparam int THR_W     = 36;
	localparam int CFG_IDX_W = 1;
	localparam logic [THR_W-1:0] THR_RESET = 36'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LINE_MODE = 1'b0,
		CFG_DEGEN_THR = 1'b1
	} cfg_reg_t;

	// Result flags on the master-side tuser.
	localparam int USER_W          = 2;
	localparam int USER_DEGENERATE = 0;
	localparam int USER_SATURATED  = 1;

	// Per-item decisions made ahead of the divider.
	typedef struct packed {
		logic degenerate;
		logic tneg;
		logic force_zero;
		logic force_one;
		logic cap;
	} ctl_t;

endpackage

>>> hdl/cpl_front.sv
// Front end: differences, dot products and the per-item decisions (four stages).
// Depends on cpl_pkg.
module cpl_front
	import cpl_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic [3*COORD_BITS-1:0]   in_start,
	input  logic [3*COORD_BITS-1:0]   in_end,
	input  logic [3*COORD_BITS-1:0]   in_query,
	input  logic                      line_mode,
	input  logic [THR_W-1:0]          degen_thr,
	output logic                      out_valid,
	output ctl_t                      out_ctl,
	output logic [2*COORD_BITS+1:0]   out_rem,
	output logic [2*COORD_BITS+1:0]   out_b,
	output logic [COORD_BITS:0]       out_nal,
	output logic [6*COORD_BITS+2:0]   out_side
);

	localparam int CB  = COORD_BITS;
	localparam int PW  = 2 * CB + 2;
	localparam int AW  = 2 * CB + 3;
	localparam int BW  = 2 * CB + 2;
	localparam int NAW = 2 * CB + 2;
	localparam int NLW = CB + 1;
	localparam int SW  = 6 * CB + 3;
	localparam int CW  = (BW > THR_W) ? BW : THR_W;

	// Stage 1: start, end - start, start - query.
	logic signed [CB:0]   d_c [3];
	logic signed [CB:0]   w_c [3];
	logic        [CB-1:0] s_s1 [3];
	logic signed [CB:0]   d_s1 [3];
	logic signed [CB:0]   w_s1 [3];
	logic                 v_s1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			d_c[i] = $signed({in_end[i*CB+CB-1], in_end[i*CB +: CB]})
				- $signed({in_start[i*CB+CB-1], in_start[i*CB +: CB]});
			w_c[i] = $signed({in_start[i*CB+CB-1], in_start[i*CB +: CB]})
				- $signed({in_query[i*CB+CB-1], in_query[i*CB +: CB]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				s_s1[i] <= in_start[i*CB +: CB];
				d_s1[i] <= d_c[i];
				w_s1[i] <= w_c[i];
			end
		end
	end

	// Stage 2: products, and the axis magnitudes used by the back end.
	logic signed [PW-1:0]   pw_c [3];
	logic signed [PW-1:0]   pd_c [3];
	logic signed [CB:0]     ad_c [3];
	logic        [SW-1:0]   side_c;
	logic signed [PW-1:0]   pw_s2 [3];
	logic        [2*CB-1:0] pd_s2 [3];
	logic        [SW-1:0]   side_s2;
	logic                   v_s2;

	always_comb begin
		side_c = '0;
		for (int i = 0; i < 3; i++) begin
			pw_c[i] = d_s1[i] * w_s1[i];
			pd_c[i] = d_s1[i] * d_s1[i];
			ad_c[i] = d_s1[i][CB] ? -d_s1[i] : d_s1[i];
			side_c[i*CB +: CB]      = s_s1[i];
			side_c[3*CB+i*CB +: CB] = ad_c[i][CB-1:0];
			side_c[6*CB+i]          = d_s1[i][CB];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pw_s2[i] <= pw_c[i];
				pd_s2[i] <= pd_c[i][2*CB-1:0];
			end
			side_s2 <= side_c;
		end
	end

	// Stage 3: A and B.
	logic signed [AW-1:0] a_c;
	logic        [BW-1:0] b_c;
	logic signed [AW-1:0] a_s3;
	logic        [BW-1:0] b_s3;
	logic        [SW-1:0] side_s3;
	logic                 v_s3;

	assign a_c = AW'(pw_s2[0]) + AW'(pw_s2[1]) + AW'(pw_s2[2]);
	assign b_c = BW'(pd_s2[0]) + BW'(pd_s2[1]) + BW'(pd_s2[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s3    <= a_c;
			b_s3    <= b_c;
			side_s3 <= side_s2;
		end
	end

	// Stage 4: magnitude of A, degenerate test, segment ends and the cap.
	logic                 a_neg;
	logic signed [AW-1:0] na_full;
	logic [NAW-1:0]       na;
	logic [NAW-NLW-1:0]   na_hi;
	ctl_t                 ctl_c;
	ctl_t                 ctl_s4;
	logic [BW-1:0]        rem_s4;
	logic [BW-1:0]        b_s4;
	logic [NLW-1:0]       nal_s4;
	logic [SW-1:0]        side_s4;
	logic                 v_s4;

	always_comb begin
		a_neg   = a_s3[AW-1];
		na_full = a_neg ? -a_s3 : a_s3;
		na      = na_full[NAW-1:0];
		na_hi   = na[NAW-1:NLW];
		ctl_c.degenerate = (b_s3 == '0) || (line_mode && (CW'(b_s3) < CW'(degen_thr)));
		ctl_c.tneg       = !a_neg && (a_s3 != '0);
		ctl_c.force_zero = !line_mode && !a_neg;
		ctl_c.force_one  = !line_mode && a_neg && (na >= b_s3);
		// Quotient would not fit the integer bits: the magnitude is capped instead.
		ctl_c.cap        = line_mode && (BW'(na_hi) >= b_s3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s4  <= ctl_c;
			rem_s4  <= BW'(na_hi);
			b_s4    <= b_s3;
			nal_s4  <= na[NLW-1:0];
			side_s4 <= side_s3;
		end
	end

	assign out_valid = v_s4;
	assign out_ctl   = ctl_s4;
	assign out_rem   = rem_s4;
	assign out_b     = b_s4;
	assign out_nal   = nal_s4;
	assign out_side  = side_s4;

endmodule

>>> hdl/cpl_div_stage.sv
// One restoring-division step of the T = |A| / B divider: one quotient bit per stage.
// Depends on cpl_pkg.
module cpl_div_stage
	import cpl_pkg::*;
#(
	parameter int COORD_BITS      = COORD_BITS_DEF,
	parameter int PARAM_FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 in_valid,
	input  ctl_t                                 in_ctl,
	input  logic [2*COORD_BITS+1:0]              in_rem,
	input  logic [2*COORD_BITS+1:0]              in_b,
	input  logic [COORD_BITS:0]                  in_nal,
	input  logic [COORD_BITS+PARAM_FRAC_BITS+1:0] in_quo,
	input  logic [6*COORD_BITS+2:0]              in_side,
	output logic                                 out_valid,
	output ctl_t                                 out_ctl,
	output logic [2*COORD_BITS+1:0]              out_rem,
	output logic [2*COORD_BITS+1:0]              out_b,
	output logic [COORD_BITS:0]                  out_nal,
	output logic [COORD_BITS+PARAM_FRAC_BITS+1:0] out_quo,
	output logic [6*COORD_BITS+2:0]              out_side
);

	localparam int BW  = 2 * COORD_BITS + 2;
	localparam int NLW = COORD_BITS + 1;
	localparam int QW  = COORD_BITS + PARAM_FRAC_BITS + 2;
	localparam int SW  = 6 * COORD_BITS + 3;

	// The dividend's low bits enter one per step; once they run out, zeros
	// follow and the steps produce fraction bits.
	logic [BW:0]    trial;
	logic [BW:0]    diff;
	logic           ge;
	logic [BW-1:0]  rem_c;

	logic           v_s1;
	ctl_t           ctl_s1;
	logic [BW-1:0]  rem_s1;
	logic [BW-1:0]  b_s1;
	logic [NLW-1:0] nal_s1;
	logic [QW-1:0]  quo_s1;
	logic [SW-1:0]  side_s1;

	always_comb begin
		trial = {in_rem, in_nal[NLW-1]};
		diff  = trial - {1'b0, in_b};
		ge    = trial >= {1'b0, in_b};
		rem_c = ge ? diff[BW-1:0] : trial[BW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1  <= in_ctl;
			rem_s1  <= rem_c;
			b_s1    <= in_b;
			nal_s1  <= {in_nal[NLW-2:0], 1'b0};
			quo_s1  <= {in_quo[QW-2:0], ge};
			side_s1 <= in_side;
		end
	end

	assign out_valid = v_s1;
	assign out_ctl   = ctl_s1;
	assign out_rem   = rem_s1;
	assign out_b     = b_s1;
	assign out_nal   = nal_s1;
	assign out_quo   = quo_s1;
	assign out_side  = side_s1;

endmodule

>>> hdl/cpl_back.sv
// Back end: rounds T, applies the segment and cap overrides, scales each axis,
// rounds and saturates the coordinates (four stages). Depends on cpl_pkg.
module cpl_back
	import cpl_pkg::*;
#(
	parameter int COORD_BITS      = COORD_BITS_DEF,
	parameter int PARAM_FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 in_valid,
	input  ctl_t                                 in_ctl,
	input  logic [COORD_BITS+PARAM_FRAC_BITS+1:0] in_quo,
	input  logic [6*COORD_BITS+2:0]              in_side,
	output logic                                 out_valid,
	output logic [3*COORD_BITS-1:0]              out_near,
	output logic                                 out_degenerate,
	output logic                                 out_saturated
);

	localparam int CB   = COORD_BITS;
	localparam int FB   = PARAM_FRAC_BITS;
	localparam int QW   = CB + FB + 2;
	localparam int TIW  = CB + 2;
	localparam int SW   = 6 * CB + 3;
	localparam int PIW  = TIW + CB;
	localparam int PFW  = FB + CB;
	localparam int FSW  = PFW + 1;
	localparam int MW   = 2 * CB + 3;
	localparam int RSW  = 2 * CB + 5;
	localparam logic [FSW-1:0] HALF = FSW'(1) << (FB - 1);

	// Stage 1: T rounded to FB fraction bits, half up, then the overrides.
	logic [QW-1:0]  t_c;
	logic [TIW-1:0] ti_c;
	logic [FB-1:0]  tf_c;
	logic           tneg_c;
	logic [TIW-1:0] ti_s1;
	logic [FB-1:0]  tf_s1;
	logic           tneg_s1;
	logic           deg_s1;
	logic [SW-1:0]  side_s1;
	logic           v_s1;

	always_comb begin
		t_c    = {1'b0, in_quo[QW-1:1]} + QW'(in_quo[0]);
		ti_c   = t_c[QW-1:FB];
		tf_c   = t_c[FB-1:0];
		tneg_c = in_ctl.tneg;
		if (in_ctl.cap) begin
			ti_c = TIW'(1) << (CB + 1);
			tf_c = '0;
		end else if (in_ctl.force_one) begin
			ti_c = TIW'(1);
			tf_c = '0;
		end else if (in_ctl.force_zero) begin
			ti_c   = '0;
			tf_c   = '0;
			tneg_c = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ti_s1   <= ti_c;
			tf_s1   <= tf_c;
			tneg_s1 <= tneg_c;
			deg_s1  <= in_ctl.degenerate;
			side_s1 <= in_side;
		end
	end

	// Stage 2: integer and fraction parts of T times each axis magnitude.
	logic [PIW-1:0] pi_c [3];
	logic [PFW-1:0] pf_c [3];
	logic [PIW-1:0] pi_s2 [3];
	logic [PFW-1:0] pf_s2 [3];
	logic           tneg_s2;
	logic           deg_s2;
	logic [SW-1:0]  side_s2;
	logic           v_s2;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pi_c[i] = ti_s1 * side_s1[3*CB+i*CB +: CB];
			pf_c[i] = tf_s1 * side_s1[3*CB+i*CB +: CB];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pi_s2[i] <= pi_c[i];
				pf_s2[i] <= pf_c[i];
			end
			tneg_s2 <= tneg_s1;
			deg_s2  <= deg_s1;
			side_s2 <= side_s1;
		end
	end

	// Stage 3: offset magnitude along each axis, fraction rounded half up.
	logic [FSW-1:0] fsum_c [3];
	logic [MW-1:0]  m_c [3];
	logic [MW-1:0]  m_s3 [3];
	logic [2:0]     neg_s3;
	logic           deg_s3;
	logic [3*CB-1:0] start_s3;
	logic           v_s3;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			fsum_c[i] = FSW'(pf_s2[i]) + HALF;
			m_c[i]    = MW'(pi_s2[i]) + MW'(fsum_c[i][FSW-1:FB]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				m_s3[i]   <= m_c[i];
				neg_s3[i] <= tneg_s2 ^ side_s2[6*CB+i];
			end
			deg_s3   <= deg_s2;
			start_s3 <= side_s2[3*CB-1:0];
		end
	end

	// Stage 4: add to the start, saturate, and hold the result.
	logic signed [RSW-1:0] sx_c;
	logic signed [RSW-1:0] mx_c;
	logic signed [RSW-1:0] res_c;
	logic                  fits_c;
	logic [3*CB-1:0]       near_c;
	logic                  sat_c;
	logic [3*CB-1:0]       near_s4;
	logic                  deg_s4;
	logic                  sat_s4;
	logic                  v_s4;

	always_comb begin
		sx_c   = '0;
		mx_c   = '0;
		res_c  = '0;
		fits_c = 1'b1;
		near_c = '0;
		sat_c  = 1'b0;
		for (int i = 0; i < 3; i++) begin
			sx_c   = RSW'($signed(start_s3[i*CB +: CB]));
			mx_c   = $signed(RSW'(m_s3[i]));
			res_c  = neg_s3[i] ? sx_c - mx_c : sx_c + mx_c;
			fits_c = (res_c[RSW-1:CB-1] == '0) || (&res_c[RSW-1:CB-1]);
			if (fits_c) begin
				near_c[i*CB +: CB] = res_c[CB-1:0];
			end else begin
				near_c[i*CB +: CB] = res_c[RSW-1] ? {1'b1, {(CB-1){1'b0}}}
					: {1'b0, {(CB-1){1'b1}}};
				sat_c = 1'b1;
			end
		end
		// A degenerate line returns the start untouched.
		if (deg_s3) begin
			near_c = start_s3;
			sat_c  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			near_s4 <= near_c;
			deg_s4  <= deg_s3;
			sat_s4  <= sat_c;
		end
	end

	assign out_valid      = v_s4;
	assign out_near       = near_s4;
	assign out_degenerate = deg_s4;
	assign out_saturated  = sat_s4;

endmodule

>>> hdl/closest_point_on_line_3d.sv
// Closest point on a 3-D line or segment: slave stream of queries, master stream
// of points, plain configuration write port.
//
// The slave side takes one query per transaction: start, end and query point,
// three signed coordinates each. The master side returns the nearest point on
// the line through start and end, with a degenerate and a saturated flag.
// line_mode selects segment (0) or infinite line (1); degenerate_threshold sets
// the shortest squared length accepted in infinite mode. Write them only while
// no transaction is in flight.
//
// The pipeline has four front stages for the dot products, one stage per quotient
// bit in the divider, and four back stages for rounding, scaling and saturation.
// Throughput is one transaction per cycle while the master side does not stall;
// the divider is fully unrolled.
//
// Reset clears every valid bit and loads line_mode = 0 and a threshold of 1.
// While the master side holds a result that is not taken, the whole pipeline
// holds and s_tready is low; nothing is dropped or repeated.
module closest_point_on_line_3d
	import cpl_pkg::*;
#(
	parameter int COORD_BITS      = COORD_BITS_DEF,
	parameter int PARAM_FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]                  cfg_index,
	input  logic [THR_W-1:0]                      cfg_data,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// start_x, start_y, start_z, end_x, end_y, end_z, query_x, query_y, query_z
	input  logic [((9*COORD_BITS+7)/8)*8-1:0]     s_tdata,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// near_x, near_y, near_z
	output logic [((3*COORD_BITS+7)/8)*8-1:0]     m_tdata,
	// degenerate, saturated
	output logic [USER_W-1:0]                     m_tuser
);

	localparam int CB    = COORD_BITS;
	localparam int OUT_W = ((3 * CB + 7) / 8) * 8;
	localparam int BW    = 2 * CB + 2;
	localparam int NLW   = CB + 1;
	localparam int QW    = CB + PARAM_FRAC_BITS + 2;
	localparam int SW    = 6 * CB + 3;
	localparam int NDIV  = QW;
	localparam int LAT   = NDIV + 8;
	localparam int OCC_W = $clog2(LAT + 1);

	// Configuration registers.
	logic             line_mode_q;
	logic [THR_W-1:0] degen_thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_mode_q <= 1'b0;
			degen_thr_q <= THR_RESET;
		end else if (cfg_wen) begin
			case (cfg_reg_t'(cfg_index))
				CFG_LINE_MODE: begin
					line_mode_q <= cfg_data[0];
				end
				CFG_DEGEN_THR: begin
					degen_thr_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// The pipeline moves as one; it holds only while a result waits.
	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	logic           v_d    [NDIV+1];
	ctl_t           ctl_d  [NDIV+1];
	logic [BW-1:0]  rem_d  [NDIV+1];
	logic [BW-1:0]  b_d    [NDIV+1];
	logic [NLW-1:0] nal_d  [NDIV+1];
	logic [QW-1:0]  quo_d  [NDIV+1];
	logic [SW-1:0]  side_d [NDIV+1];

	cpl_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.in_start  (s_tdata[3*CB-1:0]),
		.in_end    (s_tdata[6*CB-1:3*CB]),
		.in_query  (s_tdata[9*CB-1:6*CB]),
		.line_mode (line_mode_q),
		.degen_thr (degen_thr_q),
		.out_valid (v_d[0]),
		.out_ctl   (ctl_d[0]),
		.out_rem   (rem_d[0]),
		.out_b     (b_d[0]),
		.out_nal   (nal_d[0]),
		.out_side  (side_d[0])
	);

	assign quo_d[0] = '0;

	for (genvar k = 0; k < NDIV; k++) begin : g_div
		cpl_div_stage #(
			.COORD_BITS      (COORD_BITS),
			.PARAM_FRAC_BITS (PARAM_FRAC_BITS)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (v_d[k]),
			.in_ctl    (ctl_d[k]),
			.in_rem    (rem_d[k]),
			.in_b      (b_d[k]),
			.in_nal    (nal_d[k]),
			.in_quo    (quo_d[k]),
			.in_side   (side_d[k]),
			.out_valid (v_d[k+1]),
			.out_ctl   (ctl_d[k+1]),
			.out_rem   (rem_d[k+1]),
			.out_b     (b_d[k+1]),
			.out_nal   (nal_d[k+1]),
			.out_quo   (quo_d[k+1]),
			.out_side  (side_d[k+1])
		);
	end

	logic [3*CB-1:0] near;
	logic            degenerate;
	logic            saturated;

	cpl_back #(
		.COORD_BITS      (COORD_BITS),
		.PARAM_FRAC_BITS (PARAM_FRAC_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (en),
		.in_valid       (v_d[NDIV]),
		.in_ctl         (ctl_d[NDIV]),
		.in_quo         (quo_d[NDIV]),
		.in_side        (side_d[NDIV]),
		.out_valid      (m_tvalid),
		.out_near       (near),
		.out_degenerate (degenerate),
		.out_saturated  (saturated)
	);

	assign m_tdata = OUT_W'(near);

	always_comb begin
		m_tuser                  = '0;
		m_tuser[USER_DEGENERATE] = degenerate;
		m_tuser[USER_SATURATED]  = saturated;
	end

	// Transactions in flight, for the checks below.
	logic             in_acc;
	logic             out_acc;
	logic [OCC_W-1:0] occ_q;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (in_acc && !out_acc) begin
			occ_q <= occ_q + OCC_W'(1);
		end else if (!in_acc && out_acc) begin
			occ_q <= occ_q - OCC_W'(1);
		end
	end

	a_occ_max: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(LAT))
		else $error("more transactions in flight than pipeline stages");

	a_empty_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q == '0) |-> !m_tvalid)
		else $error("result presented with no transaction in flight");

	a_idle_out_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while no result is waiting");

endmodule

>>> test/closest_point_on_line_3d_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for closest_point_on_line_3d: drives query streams under
// several line modes and thresholds and scores every returned point.
// Depends on cpl_pkg and the closest_point_on_line_3d RTL only.
module closest_point_on_line_3d_test;
	import cpl_pkg::*;

	localparam int CW = COORD_BITS_DEF;
	localparam int FB = FRAC_BITS_DEF;
	localparam int SW = ((9*CW+7)/8)*8;
	localparam int MW = ((3*CW+7)/8)*8;
	localparam logic [THR_W-1:0] THR_MAX = {THR_W{1'b1}};

	typedef logic signed [CW-1:0] coord_t;

	typedef struct packed {
		coord_t query_z, query_y, query_x;
		coord_t end_z, end_y, end_x;
		coord_t start_z, start_y, start_x;
	} query_t;

	typedef struct packed {
		coord_t near_x, near_y, near_z;
		logic degenerate;
		logic saturated;
	} near_t;

	// Holds the expected nearest points in acceptance order, along with the
	// register values the block used when each query was taken.
	class point_board;
		bit line_mode = 1'b0;
		logic [THR_W-1:0] threshold = THR_RESET;
		near_t pending_q[$];
		int errors = 0;

		function near_t closest_point(query_t qi);
			longint s[3], e[3], q[3], d[3];
			longint a, res, lo, hi;
			longint unsigned b, na, ti, tf, r, m, ad, one_f;
			bit tneg, sat, neg;
			near_t o;
			s[0] = longint'(qi.start_x); s[1] = longint'(qi.start_y);
			s[2] = longint'(qi.start_z);
			e[0] = longint'(qi.end_x);   e[1] = longint'(qi.end_y);
			e[2] = longint'(qi.end_z);
			q[0] = longint'(qi.query_x); q[1] = longint'(qi.query_y);
			q[2] = longint'(qi.query_z);
			a = 0;
			b = 0;
			for (int i = 0; i < 3; i++) begin
				d[i] = e[i] - s[i];
				a += (s[i] - q[i]) * d[i];
				b += longint'(d[i] * d[i]);
			end
			o = '0;
			if (b == 0 || (line_mode && b < longint'(threshold))) begin
				o.near_x = coord_t'(s[0]);
				o.near_y = coord_t'(s[1]);
				o.near_z = coord_t'(s[2]);
				o.degenerate = 1'b1;
				return o;
			end
			one_f = longint'(1) << FB;
			na = (a < 0) ? -a : a;
			tneg = (a > 0);
			ti = 0;
			tf = 0;
			r = 0;
			if (!line_mode) begin
				if (a >= 0) begin
					tneg = 1'b0;
				end else if (na >= b) begin
					ti = 1;
				end else begin
					r = na;
				end
			end else if ((na >> (CW + 1)) >= b) begin
				ti = longint'(1) << (CW + 1);
			end else begin
				ti = na / b;
				r = na % b;
			end
			// Restoring division for the fraction bits, then round half up.
			if (r != 0) begin
				for (int k = 0; k < FB; k++) begin
					r = r << 1;
					tf = tf << 1;
					if (r >= b) begin
						r -= b;
						tf |= 1;
					end
				end
				if ((r << 1) >= b) begin
					tf += 1;
					if (tf == one_f) begin
						tf = 0;
						ti += 1;
					end
				end
			end
			lo = -(longint'(1) << (CW - 1));
			hi = (longint'(1) << (CW - 1)) - 1;
			sat = 1'b0;
			for (int i = 0; i < 3; i++) begin
				ad = (d[i] < 0) ? -d[i] : d[i];
				m = ti * ad + ((tf * ad + (one_f >> 1)) >> FB);
				neg = tneg != (d[i] < 0);
				res = neg ? s[i] - longint'(m) : s[i] + longint'(m);
				if (res < lo) begin
					res = lo;
					sat = 1'b1;
				end else if (res > hi) begin
					res = hi;
					sat = 1'b1;
				end
				case (i)
					0: o.near_x = coord_t'(res);
					1: o.near_y = coord_t'(res);
					default: o.near_z = coord_t'(res);
				endcase
			end
			o.saturated = sat;
			return o;
		endfunction

		function void note_query(query_t qi);
			pending_q.push_back(closest_point(qi));
		endfunction

		function int outstanding();
			return pending_q.size();
		endfunction

		function void compare(string field, longint want, longint got);
			if (want != got) begin
				errors++;
				$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
			end
		endfunction

		function void check_point(near_t got);
			near_t want;
			if (pending_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected point (%0d, %0d, %0d) with no query pending",
					$time, got.near_x, got.near_y, got.near_z);
				return;
			end
			want = pending_q.pop_front();
			compare("near_x", longint'(want.near_x), longint'(got.near_x));
			compare("near_y", longint'(want.near_y), longint'(got.near_y));
			compare("near_z", longint'(want.near_z), longint'(got.near_z));
			compare("degenerate", longint'(want.degenerate), longint'(got.degenerate));
			compare("saturated", longint'(want.saturated), longint'(got.saturated));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [THR_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [SW-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [MW-1:0] m_tdata;
	logic [USER_W-1:0] m_tuser;

	point_board board = new();
	bit calm = 1'b0;
	int hold_ask = 0;

	closest_point_on_line_3d DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#3_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// Receiver: random back-pressure, plus a long hold whenever one is asked for.
	initial begin
		int stall_left;
		int hold_seen;
		near_t got;
		stall_left = 0;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				got.near_x = m_tdata[CW-1:0];
				got.near_y = m_tdata[2*CW-1:CW];
				got.near_z = m_tdata[3*CW-1:2*CW];
				got.degenerate = m_tuser[USER_DEGENERATE];
				got.saturated = m_tuser[USER_SATURATED];
				board.check_point(got);
			end
			if (hold_ask != hold_seen) begin
				hold_seen = hold_ask;
				stall_left = 300;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= calm || ($urandom_range(99) >= 23);
			end
		end
	end

	function automatic query_t mk(int sx, int sy, int sz, int ex, int ey, int ez,
			int qx, int qy, int qz);
		query_t qi;
		qi.start_x = coord_t'(sx); qi.start_y = coord_t'(sy); qi.start_z = coord_t'(sz);
		qi.end_x = coord_t'(ex);   qi.end_y = coord_t'(ey);   qi.end_z = coord_t'(ez);
		qi.query_x = coord_t'(qx); qi.query_y = coord_t'(qy); qi.query_z = coord_t'(qz);
		return qi;
	endfunction

	function automatic coord_t jitter(int span);
		return coord_t'(int'($urandom_range(2 * span)) - span);
	endfunction

	function automatic coord_t pick_extreme();
		case ($urandom_range(5))
			0: return coord_t'(-32768);
			1: return coord_t'(32767);
			2: return coord_t'(0);
			3: return coord_t'(-1);
			4: return coord_t'(1);
			default: return coord_t'($urandom);
		endcase
	endfunction

	function automatic query_t rand_query();
		logic [159:0] raw;
		query_t qi;
		int kind;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
		qi = query_t'(raw[SW-1:0]);
		kind = $urandom_range(99);
		if (kind < 20) begin
			// Short lines, for the threshold and for large line parameters.
			qi.start_x = jitter(1000);
			qi.start_y = jitter(1000);
			qi.start_z = jitter(1000);
			qi.end_x = qi.start_x + jitter(3);
			qi.end_y = qi.start_y + jitter(3);
			qi.end_z = qi.start_z + jitter(3);
		end else if (kind < 30) begin
			qi.end_x = qi.start_x;
			qi.end_y = qi.start_y;
			qi.end_z = qi.start_z;
		end else if (kind < 42) begin
			qi.start_x = pick_extreme(); qi.start_y = pick_extreme(); qi.start_z = pick_extreme();
			qi.end_x = pick_extreme();   qi.end_y = pick_extreme();   qi.end_z = pick_extreme();
			qi.query_x = pick_extreme(); qi.query_y = pick_extreme(); qi.query_z = pick_extreme();
		end else if (kind < 52) begin
			// Query close to one end, so the segment clamp is exercised at its edges.
			if ($urandom_range(1)) begin
				qi.query_x = qi.end_x + jitter(2);
				qi.query_y = qi.end_y + jitter(2);
				qi.query_z = qi.end_z + jitter(2);
			end else begin
				qi.query_x = qi.start_x + jitter(2);
				qi.query_y = qi.start_y + jitter(2);
				qi.query_z = qi.start_z + jitter(2);
			end
		end
		return qi;
	endfunction

	task automatic send_query(input query_t qi);
		while (!calm && $urandom_range(99) < 23) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= SW'(qi);
		do @(posedge clk); while (!s_tready);
		board.note_query(qi);
	endtask

	// The sender pauses until every outstanding point has come back.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (board.outstanding() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_cfg(input bit mode, input logic [THR_W-1:0] thr);
		drain();
		cfg_wen <= 1'b1;
		cfg_index <= CFG_LINE_MODE;
		cfg_data <= THR_W'(mode);
		@(posedge clk);
		cfg_index <= CFG_DEGEN_THR;
		cfg_data <= thr;
		@(posedge clk);
		cfg_wen <= 1'b0;
		board.line_mode = mode;
		board.threshold = thr;
	endtask

	task automatic run_random(input bit mode, input logic [THR_W-1:0] thr, input int n,
			input bit steady);
		write_cfg(mode, thr);
		calm = steady;
		if (steady)
			hold_ask++;
		repeat (n) send_query(rand_query());
		calm = 1'b0;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Segment mode straight out of reset.
		send_query(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_query(mk(100, 200, 300, 100, 200, 300, -32768, -32768, -32768));
		send_query(mk(0, 0, 0, 100, 0, 0, -50, 7, 7));
		send_query(mk(0, 0, 0, 100, 0, 0, 0, 500, -500));
		send_query(mk(0, 0, 0, 100, 0, 0, 300, 0, 0));
		send_query(mk(0, 0, 0, 100, 0, 0, 100, 0, 0));
		send_query(mk(0, 0, 0, 3, 7, -5, 1, 2, 3));
		send_query(mk(-32768, -32768, -32768, 32767, 32767, 32767, 32767, -32768, 0));
		send_query(mk(32767, 32767, 32767, -32768, -32768, -32768, 0, 0, 0));

		// Infinite line with a zero threshold: only a zero length is degenerate.
		write_cfg(1'b1, '0);
		send_query(mk(-32768, 32767, 5, -32768, 32767, 5, 1, 1, 1));
		send_query(mk(32760, 0, 0, 32767, 1, 0, 32767, 32767, 32767));
		send_query(mk(-32760, 0, 0, -32767, 1, 1, 32767, -32768, -32768));
		send_query(mk(0, 0, 0, 1, 1, 0, 32767, 32767, -32768));
		send_query(mk(-32768, -32768, -32768, -32767, -32768, -32768, 32767, 32767, 32767));
		send_query(mk(5, 5, 5, 6, 5, 5, -100, 3, 3));

		// Threshold of 50: squared lengths of 49 and 3 fall short, 50 does not.
		write_cfg(1'b1, 36'd50);
		send_query(mk(0, 0, 0, 7, 0, 0, 1000, 0, 0));
		send_query(mk(0, 0, 0, 7, 1, 0, 1000, 2000, 3000));
		send_query(mk(-32768, 32767, 0, -32767, 32766, 1, 0, 0, 0));

		// Segment mode ignores even the largest threshold.
		write_cfg(1'b0, THR_MAX);
		send_query(mk(1, 1, 1, 2, 1, 1, 5, 5, 5));
		send_query(mk(0, 0, 0, 2, 0, 0, 1, 9, 9));
		send_query(mk(0, 0, 0, 3, 0, 0, 1, 0, 0));
		send_query(mk(-7, 3, 11, 9, -4, 2, -1, 0, 5));

		run_random(1'b0, THR_W'({$urandom, $urandom}), 350, 1'b0);
		run_random(1'b1, '0, 300, 1'b0);
		run_random(1'b1, 36'd1, 300, 1'b1);
		run_random(1'b1, THR_W'($urandom_range(1, 200)), 300, 1'b0);
		run_random(1'b1, THR_MAX, 100, 1'b0);
		run_random(1'b0, '0, 200, 1'b0);
		run_random(1'b1, THR_W'($urandom), 200, 1'b0);

		drain();
		repeat (50) @(posedge clk);
		if (board.errors == 0 && board.outstanding() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
